// ===== design/nearest_obstacle_velocity_assert.svh =====
// Assertion macros for the nearest obstacle velocity block.
// Taken in by the RTL files that carry concurrent checks; no other dependency.
`ifndef NEAREST_OBSTACLE_VELOCITY_ASSERT_SVH
`define NEAREST_OBSTACLE_VELOCITY_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on the rising edge, ignored while reset is low.
`define NOV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen on a rising edge.
`define NOV_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `NOV_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define NOV_ASSERT(lbl, clk, rst_n, prop, msg)
`define NOV_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/nov_pkg.sv =====
// Shared types and constants for the nearest obstacle velocity block.
// No dependencies; used by every module of the block except nov_fifo.
package nov_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_RANGE_FLOOR    = 3'd0,
    REG_NEAR_THRESHOLD = 3'd1,
    REG_START_ANGLE    = 3'd2,
    REG_ANGLE_STEP     = 3'd3,
    REG_MOUNT_OFFSET   = 3'd4,
    REG_SPEED_GAIN     = 3'd5
  } cfg_reg_e;

  localparam logic [15:0] RANGE_FLOOR_RST    = 16'd20;
  localparam logic [15:0] NEAR_THRESHOLD_RST = 16'd200;
  localparam logic [15:0] START_ANGLE_RST    = 16'hAB02;  // -21758
  localparam logic [15:0] ANGLE_STEP_RST     = 16'd64;
  localparam logic [15:0] MOUNT_OFFSET_RST   = 16'd2185;
  localparam logic [15:0] SPEED_GAIN_RST     = 16'd16384;

  localparam logic [15:0] NO_RETURN = 16'hFFFF;

  localparam int unsigned MID_QUEUE_DEPTH = 4;
  localparam int unsigned OUT_QUEUE_DEPTH = 8;

  // pi/2 in Q30 and the divisors (2k)(2k+1) of the sine series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef struct packed {
    logic [15:0] range_floor;
    logic [15:0] near_threshold;
    logic [15:0] start_angle;
    logic [15:0] angle_step;
    logic [15:0] mount_offset;
    logic [15:0] speed_gain;
  } cfg_t;

  // Summary of one finished scan, front to back
  typedef struct packed {
    logic        near;
    logic [15:0] angle;
  } scan_rec_t;

  typedef struct packed {
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic        near;
    logic [15:0] angle;
  } result_t;

  // Quarter-wave sine entry in Q16 for angle x in Q30 radians; elaboration only
  function automatic logic [16:0] sine_entry(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] s;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[k-1];
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    s = (64'(sum) + 64'd8192) >> 14;
    if (s > 64'd65536) begin
      s = 64'd65536;
    end
    return s[16:0];
  endfunction

endpackage

// ===== design/nearest_obstacle_velocity.sv =====
// Channel   Handshake              Payload
// input     push / full            range_sample_i, last_sample_i
// result    empty / pop            vel_x_o, vel_y_o, obstacle_near_o, nearest_angle_o
// config    cfg_we_i, cfg_idx_i    cfg_wdata_i (16 bits, no wait, no read-back)
//
// One range sample is taken every cycle while full is low; the search is compare and add logic.
// A scan result passes the scan queue, then one stage each for angle correction,
// table read and gain multiply, then the result queue before the result ports.
// Reset clears the scan state and both queues and loads the register defaults.
// A stalled result side fills the result queue, then the scan queue, then raises full.
// Top level of the nearest obstacle velocity block.
// Depends on nov_pkg, nov_fifo, nov_front, nov_back and the assertion header.
module nearest_obstacle_velocity #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] range_sample_i,
  input  logic        last_sample_i,
  output logic        empty,
  input  logic        pop,
  output logic signed [15:0] vel_x_o,
  output logic signed [15:0] vel_y_o,
  output logic        obstacle_near_o,
  output logic signed [15:0] nearest_angle_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  nov_pkg::cfg_t      cfg_q;
  nov_pkg::scan_rec_t front_rec, mid_rec;
  nov_pkg::result_t   res;
  logic               rec_push, mid_pop, mid_empty;
  logic [$clog2(nov_pkg::MID_QUEUE_DEPTH+1)-1:0] mid_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_floor    <= nov_pkg::RANGE_FLOOR_RST;
      cfg_q.near_threshold <= nov_pkg::NEAR_THRESHOLD_RST;
      cfg_q.start_angle    <= nov_pkg::START_ANGLE_RST;
      cfg_q.angle_step     <= nov_pkg::ANGLE_STEP_RST;
      cfg_q.mount_offset   <= nov_pkg::MOUNT_OFFSET_RST;
      cfg_q.speed_gain     <= nov_pkg::SPEED_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (nov_pkg::cfg_reg_e'(cfg_idx_i))
        nov_pkg::REG_RANGE_FLOOR:    cfg_q.range_floor    <= cfg_wdata_i;
        nov_pkg::REG_NEAR_THRESHOLD: cfg_q.near_threshold <= cfg_wdata_i;
        nov_pkg::REG_START_ANGLE:    cfg_q.start_angle    <= cfg_wdata_i;
        nov_pkg::REG_ANGLE_STEP:     cfg_q.angle_step     <= cfg_wdata_i;
        nov_pkg::REG_MOUNT_OFFSET:   cfg_q.mount_offset   <= cfg_wdata_i;
        nov_pkg::REG_SPEED_GAIN:     cfg_q.speed_gain     <= cfg_wdata_i;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  nov_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_i        (full),
    .range_sample_i(range_sample_i),
    .last_sample_i (last_sample_i),
    .rec_push_o    (rec_push),
    .rec_o         (front_rec)
  );

  nov_fifo #(
    .Width($bits(nov_pkg::scan_rec_t)),
    .Depth(nov_pkg::MID_QUEUE_DEPTH)
  ) u_scan_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .wdata_i(front_rec),
    .full_o (full),
    .pop_i  (mid_pop),
    .rdata_o(mid_rec),
    .empty_o(mid_empty),
    .count_o(mid_cnt)
  );

  nov_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .mid_empty_i(mid_empty),
    .mid_rec_i  (mid_rec),
    .mid_pop_o  (mid_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign vel_x_o         = res.vel_x;
  assign vel_y_o         = res.vel_y;
  assign obstacle_near_o = res.near;
  assign nearest_angle_o = res.angle;

  `include "nearest_obstacle_velocity_assert.svh"

  `NOV_ASSERT(a_full_blocks_records, clk_i, rst_ni, full |-> (mid_cnt == 3'(nov_pkg::MID_QUEUE_DEPTH)), "full without a full scan queue")
  `NOV_ASSERT(a_pop_needs_record, clk_i, rst_ni, mid_pop |-> !mid_empty, "back end took from an empty scan queue")
  `NOV_ASSERT(a_record_then_not_empty, clk_i, rst_ni, (rec_push && !full) |=> !mid_empty, "scan record lost")

endmodule

// ===== design/nov_fifo.sv =====
// Small first-in first-out queue with show-ahead read and an occupancy count.
// Generic; no package dependency.
module nov_fifo #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== design/nov_front.sv =====
// Scan front end: beam angle tracking and running nearest-return search.
// Depends on nov_pkg; emits one scan record per marked final sample.
module nov_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nov_pkg::cfg_t     cfg_i,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [15:0]       range_sample_i,
  input  logic              last_sample_i,
  output logic              rec_push_o,
  output nov_pkg::scan_rec_t rec_o
);

  logic [15:0] best_range_q, best_range_d;
  logic [15:0] best_angle_q, best_angle_d;
  logic [15:0] beam_angle_q;
  logic        started_q;
  logic [15:0] cur_angle;
  logic        accept, hit;

  assign accept = push_i && !full_i;

  always_comb begin
    // first sample of a scan takes the start angle as it stands now
    cur_angle    = started_q ? beam_angle_q : cfg_i.start_angle;
    hit          = (range_sample_i > cfg_i.range_floor) && (range_sample_i < best_range_q);
    best_range_d = hit ? range_sample_i : best_range_q;
    best_angle_d = hit ? cur_angle : best_angle_q;
    rec_o.near   = (best_range_d < cfg_i.near_threshold);
    rec_o.angle  = best_angle_d;
    rec_push_o   = accept && last_sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_range_q <= nov_pkg::NO_RETURN;
      best_angle_q <= '0;
      beam_angle_q <= '0;
      started_q    <= 1'b0;
    end else if (accept) begin
      if (last_sample_i) begin
        best_range_q <= nov_pkg::NO_RETURN;
        best_angle_q <= '0;
        started_q    <= 1'b0;
      end else begin
        best_range_q <= best_range_d;
        best_angle_q <= best_angle_d;
        started_q    <= 1'b1;
      end
      beam_angle_q <= cur_angle + cfg_i.angle_step;
    end
  end

endmodule

// ===== design/nov_back.sv =====
// Velocity back end: angle correction, quarter-wave sine lookup, gain scaling
// and result queue. Depends on nov_pkg, nov_fifo and the assertion header.
`include "nearest_obstacle_velocity_assert.svh"

module nov_back #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nov_pkg::cfg_t      cfg_i,
  input  logic               mid_empty_i,
  input  nov_pkg::scan_rec_t mid_rec_i,
  output logic               mid_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output nov_pkg::result_t   res_o
);

  localparam int unsigned IdxW   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned ScaleW = 14 + IdxW + 1;
  localparam int unsigned OutCntW = $clog2(nov_pkg::OUT_QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            neg;
  } lookup_t;

  // quarter-wave table, built at elaboration
  logic [16:0] sine_rom [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] X = (nov_pkg::HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = nov_pkg::sine_entry(X);
  end

  function automatic lookup_t angle_lookup(logic [15:0] a);
    lookup_t         r;
    logic [ScaleW-1:0] scaled;
    logic [IdxW:0]   raw;
    logic [IdxW-1:0] idx;
    scaled = ScaleW'(a[13:0]) * ScaleW'(SINE_TABLE_DEPTH) + ScaleW'(8192);
    raw    = scaled[ScaleW-1:14];
    idx    = (raw > (IdxW+1)'(SINE_TABLE_DEPTH)) ? IdxW'(SINE_TABLE_DEPTH) : raw[IdxW-1:0];
    // odd quadrants run the table backwards
    r.idx  = a[14] ? IdxW'(SINE_TABLE_DEPTH) - idx : idx;
    r.neg  = a[15];
    return r;
  endfunction

  function automatic logic [15:0] round_sat(logic [32:0] prod, logic neg);
    logic [33:0] rnd;
    logic [17:0] mag;
    logic [15:0] r;
    rnd = {1'b0, prod} + 34'd32768;
    mag = rnd[33:16];
    if (neg) begin
      r = (mag > 18'd32768) ? 16'h8000 : 16'(18'd65536 - mag);
    end else begin
      r = (mag > 18'd32767) ? 16'h7FFF : mag[15:0];
    end
    return r;
  endfunction

  logic               s1_v_q, s2_v_q, s3_v_q;
  nov_pkg::scan_rec_t s1_rec_q, s2_rec_q, s3_rec_q;
  lookup_t            s1_x_q, s1_y_q;
  logic [16:0]        s2_tab_x_q, s2_tab_y_q;
  logic               s2_neg_x_q, s2_neg_y_q, s3_neg_x_q, s3_neg_y_q;
  logic [32:0]        s3_prod_x_q, s3_prod_y_q;
  logic [15:0]        corr;
  logic [1:0]         inflight;
  logic [OutCntW-1:0] out_cnt;
  logic               out_full;
  nov_pkg::result_t   res_d;

  assign inflight  = 2'(s1_v_q) + 2'(s2_v_q) + 2'(s3_v_q);
  // issue only with a queue slot reserved for every record in flight
  assign mid_pop_o = !mid_empty_i &&
                     ((OutCntW+1)'(out_cnt) + (OutCntW+1)'(inflight) <
                      (OutCntW+1)'(nov_pkg::OUT_QUEUE_DEPTH));
  assign corr      = mid_rec_i.angle - cfg_i.mount_offset;

  always_ff @(posedge clk_i) begin
    s1_rec_q    <= mid_rec_i;
    s1_x_q      <= angle_lookup(corr);
    s1_y_q      <= angle_lookup(corr + 16'h4000);
    s2_rec_q    <= s1_rec_q;
    s2_tab_x_q  <= sine_rom[s1_x_q.idx];
    s2_tab_y_q  <= sine_rom[s1_y_q.idx];
    s2_neg_x_q  <= s1_x_q.neg;
    s2_neg_y_q  <= s1_y_q.neg;
    s3_rec_q    <= s2_rec_q;
    s3_prod_x_q <= 33'(cfg_i.speed_gain) * 33'(s2_tab_x_q);
    s3_prod_y_q <= 33'(cfg_i.speed_gain) * 33'(s2_tab_y_q);
    s3_neg_x_q  <= s2_neg_x_q;
    s3_neg_y_q  <= s2_neg_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= mid_pop_o;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_comb begin
    res_d.near  = s3_rec_q.near;
    res_d.angle = s3_rec_q.angle;
    res_d.vel_x = s3_rec_q.near ? round_sat(s3_prod_x_q, s3_neg_x_q) : '0;
    res_d.vel_y = s3_rec_q.near ? round_sat(s3_prod_y_q, s3_neg_y_q) : '0;
  end

  nov_fifo #(
    .Width($bits(nov_pkg::result_t)),
    .Depth(nov_pkg::OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s3_v_q),
    .wdata_i(res_d),
    .full_o (out_full),
    .pop_i  (pop_i),
    .rdata_o(res_o),
    .empty_o(empty_o),
    .count_o(out_cnt)
  );

  `NOV_ASSERT_NEVER(a_out_no_overflow, clk_i, rst_ni, s3_v_q && out_full, "result queue overflow")
  `NOV_ASSERT(a_credit_bound, clk_i, rst_ni, ((OutCntW+1)'(out_cnt) + (OutCntW+1)'(inflight) <= (OutCntW+1)'(nov_pkg::OUT_QUEUE_DEPTH)), "credit exceeds queue depth")
  `NOV_ASSERT(a_issue_lands, clk_i, rst_ni, mid_pop_o |-> ##3 s3_v_q, "issued record lost in pipeline")

endmodule

// ===== tb/nearest_obstacle_velocity_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nearest_obstacle_velocity: scans of range samples in,
// one velocity result per scan out, predicted here and compared field by field.
// Depends on nov_pkg and the nearest_obstacle_velocity RTL.
module nearest_obstacle_velocity_test;

  localparam int unsigned TABLE_DEPTH     = 256;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [2:0]  REG_SPARE_A     = 3'd6;
  localparam logic [2:0]  REG_SPARE_B     = 3'd7;
  localparam logic [15:0] EMPTY_RANGE     = 16'hFFFF;
  localparam int          PIPE_PAD        = 10;
  localparam int          RX_HOLD_CYCLES  = 300;
  localparam int          LIMIT_NS        = 400000;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               near;
    logic signed [15:0] angle;
  } scan_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [15:0] range_sample_i = '0;
  logic        last_sample_i  = 1'b0;
  logic        empty;
  logic        pop            = 1'b0;
  logic signed [15:0] vel_x_o;
  logic signed [15:0] vel_y_o;
  logic        obstacle_near_o;
  logic signed [15:0] nearest_angle_o;
  logic        cfg_we_i       = 1'b0;
  logic [2:0]  cfg_idx_i      = '0;
  logic [15:0] cfg_wdata_i    = '0;

  // Shadow registers and scan state of the predictor
  logic [15:0] floor_mm, threshold_mm, start_ang, step_ang, offset_ang, gain_q16;
  logic [15:0] best_mm, best_ang, beam_ang;
  logic        scan_open;
  logic [16:0] sine_q16 [TABLE_DEPTH+1];

  scan_result_t expected_scans [$];
  int   error_count  = 0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic rx_holding   = 1'b0;
  event hold_trigger;

  nearest_obstacle_velocity u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .range_sample_i  (range_sample_i),
    .last_sample_i   (last_sample_i),
    .empty           (empty),
    .pop             (pop),
    .vel_x_o         (vel_x_o),
    .vel_y_o         (vel_y_o),
    .obstacle_near_o (obstacle_near_o),
    .nearest_angle_o (nearest_angle_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Taylor series of sin in Q30, eight terms after x
  function automatic logic [63:0] series_sine_q30(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
      if ((k % 2) == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic void build_sine_table();
    logic [63:0] s;
    for (int k = 0; k <= TABLE_DEPTH; k++) begin
      s = (series_sine_q30((QUARTER_TURN_Q30 * k) / TABLE_DEPTH) + 64'd8192) >> 14;
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      sine_q16[k] = s[16:0];
    end
  endfunction

  // Gain times sine of a binary angle, rounded and saturated to 16 bits signed
  function automatic logic [15:0] gain_times_sine(logic [15:0] a);
    logic [1:0]  quad;
    logic [31:0] idx;
    logic [63:0] mag;
    quad = a[15:14];
    idx  = ({18'd0, a[13:0]} * TABLE_DEPTH + 32'd8192) >> 14;
    if (idx > TABLE_DEPTH) begin
      idx = TABLE_DEPTH;
    end
    if (quad[0]) begin
      idx = TABLE_DEPTH - idx;
    end
    mag = (64'(gain_q16) * 64'(sine_q16[idx]) + 64'd32768) >> 16;
    if (quad[1]) begin
      if (mag > 64'd32768) begin
        mag = 64'd32768;
      end
      mag = 64'h10000 - mag;
    end else if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[15:0];
  endfunction

  function automatic void clear_scan_state();
    best_mm   = EMPTY_RANGE;
    best_ang  = '0;
    beam_ang  = start_ang;
    scan_open = 1'b0;
  endfunction

  // Advance the scan by one accepted sample; queue a result on the last one
  function automatic void track_sample(logic [15:0] range, logic last);
    scan_result_t r;
    logic [15:0]  corr;
    if (!scan_open) begin
      beam_ang  = start_ang;
      scan_open = 1'b1;
    end
    if (range > floor_mm && range < best_mm) begin
      best_mm  = range;
      best_ang = beam_ang;
    end
    beam_ang = beam_ang + step_ang;
    if (last) begin
      if (best_mm < threshold_mm) begin
        corr    = best_ang - offset_ang;
        r.vel_x = gain_times_sine(corr);
        r.vel_y = gain_times_sine(corr + 16'h4000);
        r.near  = 1'b1;
      end else begin
        r.vel_x = '0;
        r.vel_y = '0;
        r.near  = 1'b0;
      end
      r.angle = best_ang;
      expected_scans.push_back(r);
      clear_scan_state();
    end
  endfunction

  // Ranges biased towards the floor and threshold edges, with some full-scale noise
  function automatic logic [15:0] pick_range();
    int hi;
    hi = int'(threshold_mm) + 64;
    if (hi > 65535) begin
      hi = 65535;
    end
    case ($urandom_range(9))
      0:       return EMPTY_RANGE;
      1, 2:    return 16'($urandom_range(65535));
      3:       return floor_mm + 16'($urandom_range(2)) - 16'd1;
      4:       return threshold_mm + 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom_range(hi));
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      nov_pkg::REG_RANGE_FLOOR:    floor_mm     = data;
      nov_pkg::REG_NEAR_THRESHOLD: threshold_mm = data;
      nov_pkg::REG_START_ANGLE:    start_ang    = data;
      nov_pkg::REG_ANGLE_STEP:     step_ang     = data;
      nov_pkg::REG_MOUNT_OFFSET:   offset_ang   = data;
      nov_pkg::REG_SPEED_GAIN:     gain_q16     = data;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [15:0] rf, input logic [15:0] nt,
                             input logic [15:0] sa, input logic [15:0] st,
                             input logic [15:0] mo, input logic [15:0] sg);
    write_reg(nov_pkg::REG_RANGE_FLOOR, rf);
    write_reg(nov_pkg::REG_NEAR_THRESHOLD, nt);
    write_reg(nov_pkg::REG_START_ANGLE, sa);
    write_reg(nov_pkg::REG_ANGLE_STEP, st);
    write_reg(nov_pkg::REG_MOUNT_OFFSET, mo);
    write_reg(nov_pkg::REG_SPEED_GAIN, sg);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one sample and hold it until the transfer; then idle at random
  task automatic send_sample(input logic [15:0] range, input logic last);
    push           <= 1'b1;
    range_sample_i <= range;
    last_sample_i  <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    track_sample(range, last);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // Drop push, wait for every expected result, then let the pipeline run dry
  task automatic settle();
    push <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk_i);
    repeat (PIPE_PAD) @(posedge clk_i);
  endtask

  task automatic send_random_scans(input int n_items);
    int sent = 0;
    int len;
    while (sent < n_items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        send_sample(pick_range(), i == len - 1);
      end
      sent += len;
    end
  endtask

  // Floor, tie, single sample, no return and threshold edges at reset values
  task automatic test_reset_defaults();
    send_sample(16'd20, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd150, 1'b0);
    send_sample(16'd150, 1'b0);
    send_sample(16'd300, 1'b1);
    send_sample(16'd21, 1'b1);
    send_sample(EMPTY_RANGE, 1'b0);
    send_sample(EMPTY_RANGE, 1'b1);
    send_sample(16'd199, 1'b1);
    send_sample(16'd200, 1'b1);
  endtask

  // Register extremes: saturated velocity, nothing qualifying, angle wrap
  task automatic test_config_extremes();
    settle();
    load_config(16'd0, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    send_sample(16'd0, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'hFFFE, 1'b1);
    settle();
    load_config(16'hFFFF, 16'd0, 16'h7FFF, 16'd1, 16'h8000, 16'd0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd40000, 1'b1);
    settle();
    load_config(16'd0, 16'hFFFF, 16'h7FFF, 16'h4000, 16'd0, 16'h8000);
    for (int i = 0; i < 5; i++) begin
      send_sample(16'd5000 - 16'(i * 1000), i == 4);
    end
  endtask

  task automatic test_unknown_index();
    settle();
    write_reg(REG_SPARE_A, 16'($urandom_range(65535)));
    write_reg(REG_SPARE_B, 16'($urandom_range(65535)));
    cfg_we_i <= 1'b0;
    send_sample(16'd100, 1'b1);
  endtask

  // A new start angle waits for the next scan; the other registers apply at once
  task automatic test_start_angle_mid_scan();
    settle();
    load_config(16'd20, 16'd500, 16'h0100, 16'd64, 16'd2185, 16'd16384);
    send_sample(16'd600, 1'b0);
    send_sample(16'd90, 1'b0);
    send_sample(16'd400, 1'b0);
    settle();
    write_reg(nov_pkg::REG_START_ANGLE, 16'h1234);
    write_reg(nov_pkg::REG_ANGLE_STEP, 16'd1000);
    write_reg(nov_pkg::REG_RANGE_FLOOR, 16'd60);
    write_reg(nov_pkg::REG_SPEED_GAIN, 16'd40000);
    cfg_we_i <= 1'b0;
    send_sample(16'd50, 1'b0);
    send_sample(16'd70, 1'b1);
    send_sample(16'd130, 1'b1);
  endtask

  // Hold the result side long enough to fill both queues and stall the input
  task automatic test_full_backpressure();
    settle();
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    -> hold_trigger;
    for (int i = 0; i < 60; i++) begin
      send_sample(pick_range(), (i == 59) || ($urandom_range(3) != 0));
    end
  endtask

  task automatic test_random_phases();
    int idle_mix  [4] = '{0, 65, 0, 18};
    int stall_mix [4] = '{0, 0, 65, 18};
    for (int p = 0; p < 4; p++) begin
      settle();
      load_config(($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(60)),
                  ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(1000, 100)),
                  16'($urandom_range(65535)),
                  ($urandom_range(1) == 0) ? 16'($urandom_range(512))
                                           : 16'($urandom_range(65535)),
                  16'($urandom_range(65535)),
                  16'($urandom_range(65535)));
      tx_idle_pct  = idle_mix[p];
      rx_stall_pct <= stall_mix[p];
      send_random_scans(150);
    end
  endtask

  // Compare each result transfer against the oldest pending scan
  always @(posedge clk_i) begin : result_check
    scan_result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_scans.size() == 0) begin
        $error("result with no scan pending: vel_x %0d vel_y %0d near %0b angle %0d",
               vel_x_o, vel_y_o, obstacle_near_o, nearest_angle_o);
        error_count++;
      end else begin
        want = expected_scans.pop_front();
        if (vel_x_o !== want.vel_x) begin
          $error("vel_x: expected %0d, got %0d", $signed(want.vel_x), vel_x_o);
          error_count++;
        end
        if (vel_y_o !== want.vel_y) begin
          $error("vel_y: expected %0d, got %0d", $signed(want.vel_y), vel_y_o);
          error_count++;
        end
        if (obstacle_near_o !== want.near) begin
          $error("obstacle_near: expected %0b, got %0b", want.near, obstacle_near_o);
          error_count++;
        end
        if (nearest_angle_o !== want.angle) begin
          $error("nearest_angle: expected %0d, got %0d", $signed(want.angle),
                 nearest_angle_o);
          error_count++;
        end
      end
    end
    pop <= !rx_holding && ($urandom_range(99) >= rx_stall_pct);
  end

  always begin
    @(hold_trigger);
    rx_holding <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    rx_holding <= 1'b0;
  end

  initial begin
    build_sine_table();
    floor_mm     = nov_pkg::RANGE_FLOOR_RST;
    threshold_mm = nov_pkg::NEAR_THRESHOLD_RST;
    start_ang    = nov_pkg::START_ANGLE_RST;
    step_ang     = nov_pkg::ANGLE_STEP_RST;
    offset_ang   = nov_pkg::MOUNT_OFFSET_RST;
    gain_q16     = nov_pkg::SPEED_GAIN_RST;
    clear_scan_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    test_unknown_index();
    test_start_angle_mid_scan();
    test_full_backpressure();
    test_random_phases();
    settle();

    if (error_count == 0 && expected_scans.size() == 0) begin
      $display("nearest_obstacle_velocity_test: done, clean");
    end else begin
      $display("nearest_obstacle_velocity_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("nearest_obstacle_velocity_test: done, errors");
    $finish;
  end

endmodule
